>>> rtl/mmac_pkg.sv
// ----------------------------------------------------------------------------
// mmac_pkg
// Shared types and constants for the multichannel moving average and
// calibration unit.
// ----------------------------------------------------------------------------
package mmac_pkg;

    // field widths fixed by the interface
    localparam int CH_FIELD_W = 2;
    localparam int SAMPLE_W   = 12;
    localparam int TEMP_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_TEMP  = 2'd2;

    // output queue sizing
    localparam int OQ_DEPTH = 8;
    localparam int OQ_AW    = 3;
    localparam int PEND_W   = 4;

    // saturation limits
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7fff;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = 16'sh8000;

    // control tag that travels with each request through the datapath
    typedef struct packed {
        logic                  valid;
        logic [CH_FIELD_W-1:0] ch;
    } mmac_tag_t;

endpackage

>>> rtl/mmac_cal.sv
// ----------------------------------------------------------------------------
// mmac_cal
// Pipelined mean and calibration: divides the running sum by AVG through an
// exact reciprocal multiply, then applies the reference-point line and
// saturates to 16 bits signed. Four register stages, no stall.
// ----------------------------------------------------------------------------
module mmac_cal #(
    parameter int AVG   = 8,
    parameter int SUM_W = 15
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic signed [mmac_pkg::GAIN_W-1:0]       gain,
    input  logic        [mmac_pkg::SAMPLE_W-1:0]     ref_count,
    input  logic signed [mmac_pkg::TEMP_W-1:0]       ref_temp,
    input  mmac_pkg::mmac_tag_t                      in_tag,
    input  logic        [SUM_W-1:0]                  in_sum,
    output mmac_pkg::mmac_tag_t                      out_tag,
    output logic signed [mmac_pkg::TEMP_W-1:0]       out_temp
);

    // reciprocal: floor(n*M >> K) == floor(n/AVG) for every n below 2^SUM_W
    localparam int L       = $clog2(AVG);
    localparam int K       = SUM_W + L;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << K) + AVG - 1) / AVG);
    localparam int DIFF_W  = mmac_pkg::SAMPLE_W + 1;
    localparam int P2_W    = mmac_pkg::GAIN_W + DIFF_W;
    localparam int SH_W    = P2_W - 8;
    localparam int ACC_W   = SH_W + 1;

    mmac_pkg::mmac_tag_t               t2_reg, t3_reg, t4_reg, t5_reg;
    logic [PROD_W-1:0]                 p1_reg;
    logic signed [DIFF_W-1:0]          diff_reg;
    logic signed [P2_W-1:0]            p2_reg;
    logic signed [mmac_pkg::TEMP_W-1:0] temp_reg;

    logic [mmac_pkg::SAMPLE_W-1:0]     mean;
    logic signed [DIFF_W-1:0]          diff_next;
    logic signed [P2_W-1:0]            p2_next;
    logic signed [ACC_W-1:0]           acc;
    logic signed [mmac_pkg::TEMP_W-1:0] temp_next;

    // mean and signed offset from the reference count
    assign mean      = p1_reg[K +: mmac_pkg::SAMPLE_W];
    assign diff_next = signed'({1'b0, mean}) - signed'({1'b0, ref_count});

    // slope multiply
    assign p2_next   = P2_W'(gain) * P2_W'(diff_reg);

    // floor shift by 8, add the reference temperature, saturate
    assign acc = ACC_W'($signed(p2_reg[P2_W-1:8])) + ACC_W'(ref_temp);

    always_comb
    begin
        if (acc[ACC_W-1:mmac_pkg::TEMP_W-1] == '0 ||
            acc[ACC_W-1:mmac_pkg::TEMP_W-1] == '1)
        begin
            temp_next = acc[mmac_pkg::TEMP_W-1:0];
        end
        else if (acc[ACC_W-1])
        begin
            temp_next = mmac_pkg::TEMP_MIN;
        end
        else
        begin
            temp_next = mmac_pkg::TEMP_MAX;
        end
    end

    // tag pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t2_reg <= '0;
            t3_reg <= '0;
            t4_reg <= '0;
            t5_reg <= '0;
        end
        else
        begin
            t2_reg <= in_tag;
            t3_reg <= t2_reg;
            t4_reg <= t3_reg;
            t5_reg <= t4_reg;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        p1_reg   <= PROD_W'(in_sum) * PROD_W'(RECIP);
        diff_reg <= diff_next;
        p2_reg   <= p2_next;
        temp_reg <= temp_next;
    end

    assign out_tag  = t5_reg;
    assign out_temp = temp_reg;

endmodule

>>> rtl/multichannel_moving_average_calibrate_unit.sv
// ----------------------------------------------------------------------------
// multichannel_moving_average_calibrate_unit
// Per-channel moving average over the last AVG samples with a shared linear
// calibration to temperature in 1/16 degree units.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in       in   in_valid / in_ready    channel, sample
//  out      out  out_valid / out_ready  out_channel, temperature
//  cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  one request per cycle sustained while in_ready stays high; set by the
//  running-sum memory read-modify-write, which forwards the previous sum on
//  back-to-back hits; path: update stage, calibration pipeline, output queue
//  reset: no clearing pass; per-channel fill flags stand in for zeroed rings
//  stalls: an 8-entry output queue; in_ready drops with 8 results outstanding
//  a channel at or above CHANNELS is accepted and dropped
// ----------------------------------------------------------------------------
module multichannel_moving_average_calibrate_unit #(
    parameter int CHANNELS = 4,
    parameter int AVG      = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [mmac_pkg::CH_FIELD_W-1:0]         channel,
    input  logic [mmac_pkg::SAMPLE_W-1:0]           sample,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [mmac_pkg::CH_FIELD_W-1:0]         out_channel,
    output logic signed [mmac_pkg::TEMP_W-1:0]      temperature,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [mmac_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [mmac_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PTR_W  = $clog2(AVG);
    localparam int DEPTH  = CHANNELS * AVG;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = mmac_pkg::SAMPLE_W + PTR_W;

    // configuration
    logic signed [mmac_pkg::GAIN_W-1:0]   gain_reg;
    logic        [mmac_pkg::SAMPLE_W-1:0] ref_count_reg;
    logic signed [mmac_pkg::TEMP_W-1:0]   ref_temp_reg;

    // per-channel ring pointer and fill flag
    logic [PTR_W-1:0] ptr_reg    [CHANNELS];
    logic             filled_reg [CHANNELS];

    // memories
    logic [mmac_pkg::SAMPLE_W-1:0] ring_mem [DEPTH];
    logic [SUM_W-1:0]              sum_mem  [CHANNELS];
    logic [mmac_pkg::SAMPLE_W-1:0] ring_rdata_reg;
    logic [SUM_W-1:0]              sum_rdata_reg;

    // update stage
    logic                          s1_valid_reg;
    logic [CH_W-1:0]               s1_ch_reg;
    logic [ADDR_W-1:0]             s1_addr_reg;
    logic [mmac_pkg::SAMPLE_W-1:0] s1_sample_reg;
    logic                          s1_old_ok_reg;
    logic                          s1_sum_ok_reg;
    logic                          s1_hit_reg;
    logic [SUM_W-1:0]              s1_fwd_sum_reg;

    // output queue
    logic [mmac_pkg::CH_FIELD_W-1:0]    oq_ch_mem   [mmac_pkg::OQ_DEPTH];
    logic signed [mmac_pkg::TEMP_W-1:0] oq_temp_mem [mmac_pkg::OQ_DEPTH];
    logic [mmac_pkg::OQ_AW-1:0]         oq_wr_reg, oq_rd_reg;
    logic [mmac_pkg::PEND_W-1:0]        oq_cnt_reg, oq_cnt_next;
    logic [mmac_pkg::PEND_W-1:0]        pending_reg, pending_next;

    logic                          in_acc, in_range, out_acc;
    logic [CH_W-1:0]               ch_idx;
    logic [PTR_W-1:0]              ptr_cur;
    logic [ADDR_W-1:0]             rd_addr;
    logic [mmac_pkg::SAMPLE_W-1:0] old_sample;
    logic [SUM_W-1:0]              sum_old, sum_new;
    mmac_pkg::mmac_tag_t           cal_in, cal_out;
    logic signed [mmac_pkg::TEMP_W-1:0] cal_temp;

    // request decode
    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid && out_ready;
    assign in_range = 32'(channel) < CHANNELS;
    assign ch_idx   = CH_W'(channel);
    assign ptr_cur  = ptr_reg[ch_idx];
    assign rd_addr  = ADDR_W'(32'(ch_idx) * AVG + 32'(ptr_cur));
    assign in_ready = pending_reg < mmac_pkg::PEND_W'(mmac_pkg::OQ_DEPTH);
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= '0;
            ref_count_reg <= '0;
            ref_temp_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mmac_pkg::CFG_GAIN:      gain_reg      <= cfg_data;
                mmac_pkg::CFG_REF_COUNT: ref_count_reg <= cfg_data[mmac_pkg::SAMPLE_W-1:0];
                mmac_pkg::CFG_REF_TEMP:  ref_temp_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ring pointer and fill flag advance at accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                ptr_reg[i]    <= '0;
                filled_reg[i] <= 1'b0;
            end
        end
        else if (in_acc && in_range)
        begin
            if (ptr_cur == PTR_W'(AVG - 1))
            begin
                ptr_reg[ch_idx]    <= '0;
                filled_reg[ch_idx] <= 1'b1;
            end
            else
            begin
                ptr_reg[ch_idx] <= ptr_cur + 1'b1;
            end
        end
    end

    // update stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_acc && in_range;
        end
    end

    // update stage payload, hit when the item ahead writes the same sum entry
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_ch_reg      <= ch_idx;
            s1_addr_reg    <= rd_addr;
            s1_sample_reg  <= sample;
            s1_old_ok_reg  <= filled_reg[ch_idx];
            s1_sum_ok_reg  <= filled_reg[ch_idx] || (ptr_cur != '0);
            s1_hit_reg     <= s1_valid_reg && (s1_ch_reg == ch_idx);
            s1_fwd_sum_reg <= sum_new;
        end
    end

    // memory read at accept, write back from the update stage
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            ring_mem[s1_addr_reg] <= s1_sample_reg;
            sum_mem[s1_ch_reg]    <= sum_new;
        end
        if (in_acc)
        begin
            ring_rdata_reg <= ring_mem[rd_addr];
            sum_rdata_reg  <= sum_mem[ch_idx];
        end
    end

    // running sum update; entries never written read as zero
    assign old_sample = s1_old_ok_reg ? ring_rdata_reg : '0;
    assign sum_old    = s1_hit_reg ? s1_fwd_sum_reg :
                        (s1_sum_ok_reg ? sum_rdata_reg : '0);
    assign sum_new    = sum_old - SUM_W'(old_sample) + SUM_W'(s1_sample_reg);

    assign cal_in.valid = s1_valid_reg;
    assign cal_in.ch    = mmac_pkg::CH_FIELD_W'(s1_ch_reg);

    mmac_cal #(
        .AVG   (AVG),
        .SUM_W (SUM_W)
    ) u_cal (
        .clk       (clk),
        .rst_n     (rst_n),
        .gain      (gain_reg),
        .ref_count (ref_count_reg),
        .ref_temp  (ref_temp_reg),
        .in_tag    (cal_in),
        .in_sum    (sum_new),
        .out_tag   (cal_out),
        .out_temp  (cal_temp)
    );

    // output queue and outstanding count
    always_comb
    begin
        oq_cnt_next  = oq_cnt_reg;
        pending_next = pending_reg;
        if (cal_out.valid && !out_acc)
        begin
            oq_cnt_next = oq_cnt_reg + 1'b1;
        end
        else if (!cal_out.valid && out_acc)
        begin
            oq_cnt_next = oq_cnt_reg - 1'b1;
        end
        if (in_acc && in_range && !out_acc)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (!(in_acc && in_range) && out_acc)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg   <= '0;
            oq_rd_reg   <= '0;
            oq_cnt_reg  <= '0;
            pending_reg <= '0;
        end
        else
        begin
            oq_cnt_reg  <= oq_cnt_next;
            pending_reg <= pending_next;
            if (cal_out.valid)
            begin
                oq_wr_reg <= oq_wr_reg + 1'b1;
            end
            if (out_acc)
            begin
                oq_rd_reg <= oq_rd_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cal_out.valid)
        begin
            oq_ch_mem[oq_wr_reg]   <= cal_out.ch;
            oq_temp_mem[oq_wr_reg] <= cal_temp;
        end
    end

    assign out_valid   = oq_cnt_reg != '0;
    assign out_channel = oq_ch_mem[oq_rd_reg];
    assign temperature = oq_temp_mem[oq_rd_reg];

`ifndef NO_ASSERTIONS
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= mmac_pkg::PEND_W'(mmac_pkg::OQ_DEPTH))
        else $error("outstanding request count above queue depth");

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        cal_out.valid |-> oq_cnt_reg < mmac_pkg::PEND_W'(mmac_pkg::OQ_DEPTH))
        else $error("result arrives at a full output queue");

    a_out_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg >= oq_cnt_reg && pending_reg != '0)
        else $error("queued result without outstanding request");

    a_hit_source: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_hit_reg) |-> $past(s1_valid_reg))
        else $error("sum forwarding without a write ahead");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_range) |=> s1_valid_reg)
        else $error("accepted request did not enter the update stage");
`endif

endmodule

>>> test/multichannel_moving_average_calibrate_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multichannel_moving_average_calibrate_unit_tb
// Drives channel/sample requests and calibration writes into the unit.
// A local model of the eight-deep channel windows and the shared linear
// calibration predicts each temperature. Every returned reading is checked
// in order against that prediction, under random stalls on both sides and
// one long output hold-off.
// ----------------------------------------------------------------------------
module multichannel_moving_average_calibrate_unit_tb;

    localparam int NUM_CH      = 4;
    localparam int AVG_LEN     = 8;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE_CYC  = 20;

    typedef struct {
        logic [mmac_pkg::CH_FIELD_W-1:0]    ch;
        logic signed [mmac_pkg::TEMP_W-1:0] temp;
    } temp_reading_t;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_ready;
    logic [mmac_pkg::CH_FIELD_W-1:0]    channel;
    logic [mmac_pkg::SAMPLE_W-1:0]      sample;
    logic                               out_valid;
    logic                               out_ready;
    logic [mmac_pkg::CH_FIELD_W-1:0]    out_channel;
    logic signed [mmac_pkg::TEMP_W-1:0] temperature;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [mmac_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [mmac_pkg::CFG_DATA_W-1:0]    cfg_data;

    // calibration and window state of the local model
    logic signed [mmac_pkg::GAIN_W-1:0] cal_gain;
    logic [mmac_pkg::SAMPLE_W-1:0]      cal_ref_count;
    logic signed [mmac_pkg::TEMP_W-1:0] cal_ref_temp;
    logic [mmac_pkg::SAMPLE_W-1:0]      sample_window [NUM_CH][AVG_LEN];
    logic [2:0]                         window_slot [NUM_CH];
    logic [14:0]                        window_sum [NUM_CH];

    temp_reading_t pending_readings[$];

    int error_count;
    int samples_sent;
    int readings_checked;
    int cfg_writes;
    int input_stall_cycles;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_cycles;

    multichannel_moving_average_calibrate_unit #(
        .CHANNELS (NUM_CH),
        .AVG      (AVG_LEN)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .channel     (channel),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_channel (out_channel),
        .temperature (temperature),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("%0t: timeout with %0d readings outstanding", $time,
                 pending_readings.size());
        $display("Some tests failed");
        $finish;
    end

    // window update and calibration of one sample
    function automatic temp_reading_t predict_temperature(
        input logic [mmac_pkg::CH_FIELD_W-1:0] ch,
        input logic [mmac_pkg::SAMPLE_W-1:0]   smp);
        temp_reading_t r;
        logic [2:0]    slot;
        int            mean;
        int            diff;
        longint        scaled;
        slot = window_slot[ch];
        window_sum[ch] = window_sum[ch] - 15'(sample_window[ch][slot]) + 15'(smp);
        sample_window[ch][slot] = smp;
        window_slot[ch] = (slot == AVG_LEN - 1) ? 3'd0 : slot + 3'd1;
        mean = int'(window_sum[ch]) / AVG_LEN;
        diff = mean - int'(cal_ref_count);
        // arithmetic shift gives the floor of the division by 256
        scaled = ((longint'(cal_gain) * longint'(diff)) >>> 8) + longint'(cal_ref_temp);
        if (scaled > longint'(mmac_pkg::TEMP_MAX))
            scaled = longint'(mmac_pkg::TEMP_MAX);
        if (scaled < longint'(mmac_pkg::TEMP_MIN))
            scaled = longint'(mmac_pkg::TEMP_MIN);
        r.ch   = ch;
        r.temp = scaled[mmac_pkg::TEMP_W-1:0];
        return r;
    endfunction

    // one sample request, predicted when accepted
    task automatic send_sample(input logic [mmac_pkg::CH_FIELD_W-1:0] ch,
                               input logic [mmac_pkg::SAMPLE_W-1:0]   smp);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        channel  <= ch;
        sample   <= smp;
        do
            @(posedge clk);
        while (!in_ready);
        pending_readings.push_back(predict_temperature(ch, smp));
        samples_sent++;
    endtask

    // lower the request and wait until every reading is back
    task automatic wait_for_readings();
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_readings.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_readings.size() != 0)
        begin
            $display("%0t: %0d readings never arrived", $time, pending_readings.size());
            error_count++;
        end
    endtask

    // calibration register write, only with the unit idle
    task automatic write_register(input logic [mmac_pkg::CFG_IDX_W-1:0]  idx,
                                  input logic [mmac_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            mmac_pkg::CFG_GAIN:      cal_gain      = data;
            mmac_pkg::CFG_REF_COUNT: cal_ref_count = data[mmac_pkg::SAMPLE_W-1:0];
            mmac_pkg::CFG_REF_TEMP:  cal_ref_temp  = data;
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_calibration(input logic [mmac_pkg::CFG_DATA_W-1:0] g,
                                     input logic [mmac_pkg::CFG_DATA_W-1:0] rc,
                                     input logic [mmac_pkg::CFG_DATA_W-1:0] rt);
        write_register(mmac_pkg::CFG_GAIN, g);
        write_register(mmac_pkg::CFG_REF_COUNT, rc);
        write_register(mmac_pkg::CFG_REF_TEMP, rt);
    endtask

    // mix of extremes, small and full-range signed values
    function automatic logic [mmac_pkg::CFG_DATA_W-1:0] pick_signed16(input int small_span);
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2, 3: return mmac_pkg::CFG_DATA_W'($signed($urandom_range(0, 2 * small_span))
                                                - small_span);
            default: return mmac_pkg::CFG_DATA_W'($urandom);
        endcase
    endfunction

    task automatic randomize_calibration();
        logic [mmac_pkg::CFG_DATA_W-1:0] rc;
        case ($urandom_range(0, 3))
            0: rc = 16'd0;
            1: rc = 16'd4095;
            default: rc = 16'($urandom_range(0, 4095));
        endcase
        write_calibration(pick_signed16(600), rc, pick_signed16(2000));
    endtask

    function automatic logic [mmac_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return mmac_pkg::SAMPLE_W'($urandom_range(0, 63));
            default: return mmac_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    // reset calibration maps everything to zero
    task automatic test_reset_calibration();
        send_sample(2'd0, 12'hfff);
        send_sample(2'd1, 12'h000);
        send_sample(2'd2, 12'haaa);
        send_sample(2'd3, 12'h555);
        wait_for_readings();
    endtask

    // unit slope: windows fill from the reset zeros, then begin to empty again
    task automatic test_warmup_and_extremes();
        write_calibration(16'd256, 16'd0, 16'd0);
        repeat (9) send_sample(2'd3, 12'hfff);
        send_sample(2'd1, 12'hfff);
        send_sample(2'd3, 12'h000);
        send_sample(2'd3, 12'h000);
        wait_for_readings();
    endtask

    // clamp at both ends of the temperature range
    task automatic test_saturation();
        write_calibration(16'h7fff, 16'd0, 16'h7fff);
        send_sample(2'd3, 12'hfff);
        wait_for_readings();
        write_calibration(16'h8000, 16'd0, 16'h8000);
        send_sample(2'd3, 12'hfff);
        wait_for_readings();
    endtask

    // mean below the reference point, product rounded toward minus infinity
    task automatic test_negative_difference();
        write_calibration(16'd3, 16'd4095, 16'd0);
        send_sample(2'd0, 12'd1);
        send_sample(2'd2, 12'hfff);
        send_sample(2'd1, 12'd100);
        wait_for_readings();
    endtask

    // random traffic over several calibration settings
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int settings, input int per_setting);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (settings)
        begin
            randomize_calibration();
            repeat (per_setting)
                send_sample(mmac_pkg::CH_FIELD_W'($urandom_range(0, NUM_CH - 1)),
                            pick_sample());
            wait_for_readings();
        end
    endtask

    // long output hold-off while requests keep coming
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        randomize_calibration();
        @(posedge clk);
        hold_off_cycles = 150;
        repeat (60)
            send_sample(mmac_pkg::CH_FIELD_W'($urandom_range(0, NUM_CH - 1)),
                        pick_sample());
        wait_for_readings();
    endtask

    // output ready, random or held off
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_off_cycles--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // compare each reading with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            temp_reading_t exp_r;
            if (pending_readings.size() == 0)
            begin
                $display("%0t: unexpected reading: expected none actual ch %0d temp %0d",
                         $time, out_channel, temperature);
                error_count++;
            end
            else
            begin
                exp_r = pending_readings.pop_front();
                readings_checked++;
                if (out_channel !== exp_r.ch)
                begin
                    $display("%0t: out_channel mismatch: expected %0d actual %0d",
                             $time, exp_r.ch, out_channel);
                    error_count++;
                end
                if (temperature !== exp_r.temp)
                begin
                    $display("%0t: temperature mismatch on ch %0d: expected %0d actual %0d",
                             $time, exp_r.ch, exp_r.temp, temperature);
                    error_count++;
                end
            end
        end
    end

    // input back-pressure seen
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_ready)
            input_stall_cycles++;
    end

    // test sequence
    initial
    begin
        error_count        = 0;
        samples_sent       = 0;
        readings_checked   = 0;
        cfg_writes         = 0;
        input_stall_cycles = 0;
        send_idle_pct      = 0;
        recv_idle_pct      = 0;
        hold_off_cycles    = 0;
        cal_gain           = '0;
        cal_ref_count      = '0;
        cal_ref_temp       = '0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            window_slot[c] = '0;
            window_sum[c]  = '0;
            for (int k = 0; k < AVG_LEN; k++)
                sample_window[c][k] = '0;
        end
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        channel   = '0;
        sample    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_calibration();
        test_warmup_and_extremes();
        test_saturation();
        test_negative_difference();
        test_random_traffic(24, 76, 4, 110);
        test_random_traffic(76, 24, 4, 110);
        test_random_traffic(0, 0, 4, 110);
        test_output_backpressure();

        // let any stray reading show up
        repeat (SETTLE_CYC) @(posedge clk);
        if (pending_readings.size() != 0)
        begin
            $display("%0t: %0d readings left unmatched", $time, pending_readings.size());
            error_count++;
        end

        $display("Covered %0d samples on %0d channels, %0d readings checked, %0d calibration writes.",
                 samples_sent, NUM_CH, readings_checked, cfg_writes);
        $display("Input held back for %0d cycles; %0d errors.", input_stall_cycles, error_count);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
